/* design/plqc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types for the program line queue controller.
// Depends on nothing; imported by program_line_queue_controller and tb_top.
package plqc_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int LINE_LIMIT  = 128;
  localparam int ENTRY_WIDTH = 64;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Port field widths, fixed by the stream format.
  localparam int CMD_W    = 3;
  localparam int WORD_W   = 64;
  localparam int LEN_W    = 8;
  localparam int CODE_W   = 4;
  localparam int STAT_W   = 3;
  localparam int RSTATE_W = 2;
  localparam int COUNT_W  = 7;
  localparam int EXEC_W   = 32;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 3'd0,
    CMD_CLEAR     = 3'd1,
    CMD_RUN       = 3'd2,
    CMD_PAUSE     = 3'd3,
    CMD_RESUME    = 3'd4,
    CMD_STOP      = 3'd5,
    CMD_ADVANCE   = 3'd6,
    CMD_SET_ERROR = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_LENGTH   = 3'd2,
    STAT_STATE    = 3'd3,
    STAT_REJECTED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    RUN_IDLE    = 4'b0001,
    RUN_RUNNING = 4'b0010,
    RUN_PAUSED  = 4'b0100,
    RUN_ERROR   = 4'b1000
  } run_state_t;

  localparam logic [RSTATE_W-1:0] RCODE_IDLE    = 2'd0;
  localparam logic [RSTATE_W-1:0] RCODE_RUNNING = 2'd1;
  localparam logic [RSTATE_W-1:0] RCODE_PAUSED  = 2'd2;
  localparam logic [RSTATE_W-1:0] RCODE_ERROR   = 2'd3;

  function automatic logic [RSTATE_W-1:0] run_code(input run_state_t s);
    logic [RSTATE_W-1:0] c;
    c = RCODE_IDLE;
    unique case (s)
      RUN_IDLE:    c = RCODE_IDLE;
      RUN_RUNNING: c = RCODE_RUNNING;
      RUN_PAUSED:  c = RCODE_PAUSED;
      RUN_ERROR:   c = RCODE_ERROR;
      default:     c = RCODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

/* design/program_line_queue_controller.sv */
`timescale 1ns / 1ps
// Program line queue controller: ring queue of entry words plus run control.
// Depends on plqc_pkg.
//
// One command word in gives one result word out, in the cycle after it is
// accepted. A command can be accepted in every cycle in which the result
// register is empty or being taken: the whole command is decoded
// combinationally and applied against the queue pointers and the run state, and
// the result sits in one output register. The head entry comes from the entry
// store's registered read port, addressed by the updated read position, so
// it lands in the output register together with the other fields. The store
// needs no clearing after reset; only entries written since the last reset,
// clear or stop are ever shown.
module program_line_queue_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [63:0] line_word, [71:64] line_length, [75:72] check_code, [79:76] zero
  input  logic [plqc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] cmd
  input  logic [plqc_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] status, [6:3] reject_code, [8:7] run_state, [15:9] line_count,
  // [22:16] free_slots, [54:23] executed_total, [55] head_valid,
  // [119:56] head_word
  output logic [plqc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import plqc_pkg::*;

  logic                   accept;
  cmd_t                   cmd;
  logic [WORD_W-1:0]      line_word;
  logic [LEN_W-1:0]       line_length;
  logic [CODE_W-1:0]      check_code;

  logic [ENTRY_WIDTH-1:0] line_mem [QUEUE_DEPTH];
  logic [ENTRY_WIDTH-1:0] head_r;

  run_state_t             state_r, state_nxt;
  logic [PTR_W-1:0]       wr_pos_r, wr_pos_nxt;
  logic [PTR_W-1:0]       rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [EXEC_W-1:0]      exec_r, exec_nxt;
  logic                   wr_en;

  status_t                status;
  logic [CODE_W-1:0]      reject;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [CODE_W-1:0]      out_reject_r;
  logic [RSTATE_W-1:0]    out_rstate_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic [COUNT_W-1:0]     out_free_r;
  logic [EXEC_W-1:0]      out_exec_r;
  logic                   out_hv_r;

  logic                   hv_nxt;
  logic [PTR_W:0]         ring_sum;
  logic [PTR_W-1:0]       ring_wr;

  assign in_tready   = !out_valid_r || out_tready;
  assign accept      = in_tvalid && in_tready;
  assign cmd         = cmd_t'(in_tuser);
  assign line_word   = in_tdata[63:0];
  assign line_length = in_tdata[71:64];
  assign check_code  = in_tdata[75:72];

  always_comb begin
    state_nxt  = state_r;
    wr_pos_nxt = wr_pos_r;
    rd_pos_nxt = rd_pos_r;
    count_nxt  = count_r;
    exec_nxt   = exec_r;
    wr_en      = 1'b0;
    status     = STAT_OK;
    reject     = '0;
    unique case (cmd) inside
      CMD_ADD: begin
        if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          status = STAT_FULL;
        end else if (line_length == '0 || line_length >= LEN_W'(LINE_LIMIT)) begin
          status = STAT_LENGTH;
        end else if (check_code != '0) begin
          status = STAT_REJECTED;
          reject = check_code;
        end else begin
          wr_en      = 1'b1;
          wr_pos_nxt = next_pos(wr_pos_r);
          count_nxt  = count_r + 1'b1;
        end
      end
      CMD_CLEAR, CMD_STOP: begin
        // Clear is refused while a program is live; stop needs one.
        if ((state_r == RUN_RUNNING || state_r == RUN_PAUSED) == (cmd == CMD_CLEAR)) begin
          status = STAT_STATE;
        end else begin
          state_nxt  = RUN_IDLE;
          wr_pos_nxt = '0;
          rd_pos_nxt = '0;
          count_nxt  = '0;
          exec_nxt   = '0;
        end
      end
      CMD_RUN: begin
        if (state_r != RUN_IDLE || count_r == '0) status = STAT_STATE;
        else state_nxt = RUN_RUNNING;
      end
      CMD_PAUSE: begin
        if (state_r != RUN_RUNNING) status = STAT_STATE;
        else state_nxt = RUN_PAUSED;
      end
      CMD_RESUME: begin
        if (state_r != RUN_PAUSED) status = STAT_STATE;
        else state_nxt = RUN_RUNNING;
      end
      CMD_ADVANCE: begin
        if (state_r != RUN_RUNNING) begin
          status = STAT_STATE;
        end else if (count_r == '0) begin
          state_nxt = RUN_IDLE;
        end else begin
          rd_pos_nxt = next_pos(rd_pos_r);
          count_nxt  = count_r - 1'b1;
          exec_nxt   = exec_r + 1'b1;
          if (count_r == CNT_W'(1)) state_nxt = RUN_IDLE;
        end
      end
      CMD_SET_ERROR: state_nxt = RUN_ERROR;
      default:       state_nxt = RUN_ERROR;
    endcase
  end

  assign hv_nxt = (state_nxt == RUN_RUNNING) && (count_nxt != '0);

  // Running always implies a non-empty queue, so an add never writes the
  // entry that the head read picks up in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en) line_mem[wr_pos_r] <= line_word[ENTRY_WIDTH-1:0];
      head_r <= line_mem[rd_pos_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= RUN_IDLE;
      wr_pos_r <= '0;
      rd_pos_r <= '0;
      count_r  <= '0;
      exec_r   <= '0;
    end else if (accept) begin
      state_r  <= state_nxt;
      wr_pos_r <= wr_pos_nxt;
      rd_pos_r <= rd_pos_nxt;
      count_r  <= count_nxt;
      exec_r   <= exec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_reject_r <= reject;
      out_rstate_r <= run_code(state_nxt);
      out_count_r  <= COUNT_W'(count_nxt);
      out_free_r   <= COUNT_W'(CNT_W'(QUEUE_DEPTH) - count_nxt);
      out_exec_r   <= exec_nxt;
      out_hv_r     <= hv_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(out_hv_r ? WORD_W'(head_r) : {WORD_W{1'b0}}), out_hv_r,
                       out_exec_r, out_free_r, out_count_r, out_rstate_r,
                       out_reject_r, out_status_r};

  // Write position must always sit count entries past the read position.
  assign ring_sum = {1'b0, rd_pos_r} + (PTR_W+1)'(count_r);
  assign ring_wr  = (ring_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                    PTR_W'(ring_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(ring_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == RUN_RUNNING |-> count_r != '0)
    else $error("running with an empty queue");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pos_r == ring_wr)
    else $error("write position out of step with read position and count");

  a_exec_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (exec_r == $past(exec_r) || exec_r == $past(exec_r) + 1'b1 ||
                exec_r == '0))
    else $error("executed total moved by more than one");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted command produced no result");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for program_line_queue_controller.
// Depends on plqc_pkg and the controller RTL; a local predictor checks every result word.
module tb_top;
  import plqc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PAD_W = IN_DATA_W - WORD_W - LEN_W - CODE_W;

  // Result word layout, highest field first so it matches out_tdata bit for bit.
  typedef struct packed {
    logic [WORD_W-1:0]   head_word;
    logic                head_valid;
    logic [EXEC_W-1:0]   executed;
    logic [COUNT_W-1:0]  free_slots;
    logic [COUNT_W-1:0]  line_count;
    logic [RSTATE_W-1:0] run_state;
    logic [CODE_W-1:0]   reject_code;
    logic [STAT_W-1:0]   status;
  } queue_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = CMD_ADD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Predicted queue and controller state.
  logic [WORD_W-1:0]   q_store [QUEUE_DEPTH];
  int                  q_wr;
  int                  q_rd;
  int                  q_count;
  logic [RSTATE_W-1:0] q_state;
  logic [EXEC_W-1:0]   q_executed;

  queue_result_t pending_results[$];
  queue_result_t seen_result;
  queue_result_t want_result;
  int            error_count = 0;
  int            commands_sent = 0;
  int            cycle_count = 0;
  bit            src_idle = 1'b1;
  bit            sink_idle = 1'b1;
  int            sink_hold_cycles = 0;

  program_line_queue_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_queue();
    q_wr = 0;
    q_rd = 0;
    q_count = 0;
    q_state = RCODE_IDLE;
    q_executed = '0;
  endfunction

  // Applies one command to the predicted state and returns the result word it gives.
  function automatic queue_result_t step_queue(cmd_t c, logic [WORD_W-1:0] w,
                                               logic [LEN_W-1:0] l, logic [CODE_W-1:0] k);
    queue_result_t r;
    r = '0;
    r.status = STAT_OK;
    case (c)
      CMD_ADD: begin
        if (q_count >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else if (l == 0 || l >= LINE_LIMIT) begin
          r.status = STAT_LENGTH;
        end else if (k != 0) begin
          r.status = STAT_REJECTED;
          r.reject_code = k;
        end else begin
          q_store[q_wr] = w;
          q_wr = (q_wr == QUEUE_DEPTH - 1) ? 0 : q_wr + 1;
          q_count++;
        end
      end
      CMD_CLEAR: begin
        if (q_state == RCODE_RUNNING || q_state == RCODE_PAUSED) r.status = STAT_STATE;
        else clear_queue();
      end
      CMD_RUN: begin
        if (q_state != RCODE_IDLE || q_count == 0) r.status = STAT_STATE;
        else q_state = RCODE_RUNNING;
      end
      CMD_PAUSE: begin
        if (q_state != RCODE_RUNNING) r.status = STAT_STATE;
        else q_state = RCODE_PAUSED;
      end
      CMD_RESUME: begin
        if (q_state != RCODE_PAUSED) r.status = STAT_STATE;
        else q_state = RCODE_RUNNING;
      end
      CMD_STOP: begin
        if (q_state != RCODE_RUNNING && q_state != RCODE_PAUSED) r.status = STAT_STATE;
        else clear_queue();
      end
      CMD_ADVANCE: begin
        if (q_state != RCODE_RUNNING) begin
          r.status = STAT_STATE;
        end else if (q_count == 0) begin
          q_state = RCODE_IDLE;
        end else begin
          q_rd = (q_rd == QUEUE_DEPTH - 1) ? 0 : q_rd + 1;
          q_count--;
          q_executed++;
          if (q_count == 0) q_state = RCODE_IDLE;
        end
      end
      default: begin
        q_state = RCODE_ERROR;
      end
    endcase
    r.run_state = q_state;
    r.line_count = COUNT_W'(q_count);
    r.free_slots = COUNT_W'(QUEUE_DEPTH - q_count);
    r.executed = q_executed;
    r.head_valid = (q_state == RCODE_RUNNING && q_count != 0);
    if (r.head_valid) r.head_word = q_store[q_rd];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Sends one command word; called at a rising edge and returns at the edge that took it.
  task automatic send_command(cmd_t c, logic [WORD_W-1:0] w, logic [LEN_W-1:0] l,
                              logic [CODE_W-1:0] k);
    int gap;
    bit taken;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {{PAD_W{1'b0}}, k, l, w};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (in_tready) begin
        pending_results.push_back(step_queue(c, w, l, k));
        taken = 1'b1;
      end
      @(posedge clk);
    end
    commands_sent++;
  endtask

  // A well-formed add has a legal length and a clean check verdict.
  task automatic send_add(bit well_formed);
    logic [LEN_W-1:0]  l;
    logic [CODE_W-1:0] k;
    if (well_formed) begin
      l = LEN_W'($urandom_range(1, LINE_LIMIT - 1));
      k = '0;
    end else if ($urandom_range(0, 1) == 0) begin
      l = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(LINE_LIMIT, 255));
      k = CODE_W'($urandom_range(0, 15));
    end else begin
      l = LEN_W'($urandom_range(1, LINE_LIMIT - 1));
      k = CODE_W'($urandom_range(1, 15));
    end
    send_command(CMD_ADD, {$urandom, $urandom}, l, k);
  endtask

  task automatic send_random_command();
    send_command(cmd_t'($urandom_range(0, 7)), {$urandom, $urandom},
                 LEN_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 15)));
  endtask

  // Result checker: a word is taken at the edge that follows a negedge with both high.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = out_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual 0x%0h", $time, out_tdata);
        error_count++;
      end else begin
        want_result = pending_results.pop_front();
        compare_field("status", 64'(want_result.status), 64'(seen_result.status));
        compare_field("reject_code", 64'(want_result.reject_code),
                      64'(seen_result.reject_code));
        compare_field("run_state", 64'(want_result.run_state), 64'(seen_result.run_state));
        compare_field("line_count", 64'(want_result.line_count),
                      64'(seen_result.line_count));
        compare_field("free_slots", 64'(want_result.free_slots),
                      64'(seen_result.free_slots));
        compare_field("executed_total", 64'(want_result.executed),
                      64'(seen_result.executed));
        compare_field("head_valid", 64'(want_result.head_valid),
                      64'(seen_result.head_valid));
        compare_field("head_word", want_result.head_word, seen_result.head_word);
      end
    end
  end

  // Receiver: stalls a random number of cycles before each word while sink_idle is
  // set, or a long stretch when a hold-off is requested.
  initial begin
    int  stall;
    bit  took;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = sink_idle ? $urandom_range(0, 9) : 0;
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = out_tvalid;
        @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Length check comes before the check verdict, and both before storing.
  task automatic test_add_checks();
    send_command(CMD_ADD, 64'h0123_4567_89AB_CDEF, 8'd0, 4'd0);
    send_command(CMD_ADD, 64'h0123_4567_89AB_CDEF, 8'(LINE_LIMIT), 4'd0);
    send_command(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 4'd15);
    send_command(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 4'd15);
    send_command(CMD_ADD, 64'h0, 8'(LINE_LIMIT - 1), 4'd1);
    send_command(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 4'd0);
    send_command(CMD_ADD, 64'h0, 8'(LINE_LIMIT - 1), 4'd0);
  endtask

  task automatic test_run_control();
    send_command(CMD_RUN, '0, '0, '0);
    send_command(CMD_RUN, '0, '0, '0);
    send_command(CMD_CLEAR, '0, '0, '0);
    send_command(CMD_PAUSE, '0, '0, '0);
    send_command(CMD_PAUSE, '0, '0, '0);
    send_command(CMD_ADVANCE, '0, '0, '0);
    send_command(CMD_CLEAR, '0, '0, '0);
    send_command(CMD_RESUME, '0, '0, '0);
    send_command(CMD_RESUME, '0, '0, '0);
    send_command(CMD_ADVANCE, '0, '0, '0);
    send_command(CMD_ADD, 64'hA5A5_5A5A_C3C3_3C3C, 8'd64, 4'd0);
    send_command(CMD_ADVANCE, '0, '0, '0);
    send_command(CMD_ADVANCE, '0, '0, '0);
    send_command(CMD_ADVANCE, '0, '0, '0);
    send_command(CMD_STOP, '0, '0, '0);
  endtask

  // Stop from running, then the error state, which only clear leaves.
  task automatic test_error_state();
    send_add(1'b1);
    send_command(CMD_RUN, '0, '0, '0);
    send_command(CMD_STOP, '0, '0, '0);
    send_add(1'b1);
    send_command(CMD_SET_ERROR, '0, '0, '0);
    send_command(CMD_RUN, '0, '0, '0);
    send_command(CMD_STOP, '0, '0, '0);
    send_command(CMD_CLEAR, '0, '0, '0);
    send_command(CMD_ADVANCE, '0, '0, '0);
  endtask

  // The receiver holds off while the sender keeps offering words back to back.
  task automatic test_backpressure();
    src_idle = 1'b0;
    sink_hold_cycles = 150;
    repeat (12) send_add(1'b1);
    send_command(CMD_RUN, '0, '0, '0);
    repeat (14) send_command(CMD_ADVANCE, '0, '0, '0);
    src_idle = 1'b1;
  endtask

  task automatic test_random_traffic(int num_commands);
    int stop_at;
    int pick;
    int n;
    stop_at = commands_sent + num_commands;
    while (commands_sent < stop_at) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Fill the queue; now and then far enough to hit the full check.
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 72) : $urandom_range(1, 12);
        repeat (n) send_add($urandom_range(0, 9) != 0);
      end else if (pick < 75) begin
        if (q_state == RCODE_ERROR) send_command(CMD_CLEAR, '0, '0, '0);
        if (q_count == 0) repeat ($urandom_range(1, 8)) send_add(1'b1);
        send_command(CMD_RUN, '0, '0, '0);
        repeat ($urandom_range(1, 40)) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) send_command(CMD_ADVANCE, '0, '0, '0);
          else if (pick < 70) send_command(CMD_PAUSE, '0, '0, '0);
          else if (pick < 80) send_command(CMD_RESUME, '0, '0, '0);
          else if (pick < 90) send_add(1'b1);
          else if (pick < 94) send_command(CMD_STOP, '0, '0, '0);
          else send_random_command();
        end
      end else if (pick < 85) begin
        send_command(($urandom_range(0, 1) == 0) ? CMD_CLEAR : CMD_STOP, '0, '0, '0);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) send_random_command();
      end else begin
        send_command(CMD_SET_ERROR, {$urandom, $urandom}, LEN_W'($urandom_range(0, 255)),
                     CODE_W'($urandom_range(0, 15)));
        repeat ($urandom_range(0, 3)) send_random_command();
        send_command(CMD_CLEAR, '0, '0, '0);
      end
    end
  endtask

  initial begin
    clear_queue();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_add_checks();
    test_run_control();
    test_error_state();
    test_backpressure();
    test_random_traffic(1100);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/plqc_pkg.sv
design/program_line_queue_controller.sv
test/tb_top.sv
